@@ design/gan_pkg.sv @@
// gan_pkg: shared types, constants and tables for the grid navigator
// used by gan_div, gan_ctrl, gan_dp and grid_astar_navigator
package gan_pkg;

  localparam int GRID_W     = 8;
  localparam int GRID_H     = 8;
  localparam int CELLS      = GRID_W * GRID_H;
  localparam int HEAP_DEPTH = 512;
  localparam int HEAP_AW    = 9;
  localparam int HEAP_CW    = 10;
  localparam int DIV_W      = 26;
  localparam int CELL_W     = DIV_W + 1;

  localparam logic [15:0] ORTHO_COST = 16'd256;
  localparam logic [15:0] DIAG_COST  = 16'd362;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_GRID_W    = 3'd3;
  localparam logic [2:0] REG_GRID_H    = 3'd4;

  typedef enum logic [1:0] {
    CMD_WRITE_STATIC = 2'd0,
    CMD_MARK_RECT    = 2'd1,
    CMD_QUERY        = 2'd2,
    CMD_FIND_PATH    = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_WSTAT, S_CONV_GO, S_CONV_RUN, S_DISPATCH, S_RECT_WR,
    S_POP, S_SCAN, S_POP_RD, S_POP_MOVE, S_NB_CHK, S_NB_UPD, S_TR_WR,
    S_TR_NEXT, S_EM_RD, S_EM_OUT, S_RESP
  } state_t;

  typedef struct packed {
    logic latch;
    logic wr_static;
    logic conv_start;
    logic conv_store;
    logic rect_init;
    logic rect_step;
    logic query;
    logic path_init;
    logic scan_init;
    logic scan_step;
    logic pop_rdlast;
    logic pop_move;
    logic nb_rd;
    logic nb_upd;
    logic nb_next;
    logic tr_init;
    logic tr_wr;
    logic tr_next;
    logic em_init;
    logic em_rd;
    logic em_out;
    logic resp;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic grid_ok;
    logic div_done;
    logic conv_last;
    logic rect_nonempty;
    logic rect_last;
    logic path_ok;
    logic open_empty;
    logic scan_done;
    logic at_goal;
    logic nb_skip;
    logic nb_last;
    logic tr_stop;
    logic em_last;
  } stat_t;

  function automatic logic signed [1:0] dir_dx(input logic [2:0] k);
    case (k)
      3'd0, 3'd4, 3'd5: dir_dx = 2'sd1;
      3'd1, 3'd6, 3'd7: dir_dx = -2'sd1;
      default:          dir_dx = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [2:0] k);
    case (k)
      3'd2, 3'd4, 3'd6: dir_dy = 2'sd1;
      3'd3, 3'd5, 3'd7: dir_dy = -2'sd1;
      default:          dir_dy = 2'sd0;
    endcase
  endfunction

  // rounded euclidean distance in q8
  function automatic logic [11:0] heur(input logic [2:0] dx, input logic [2:0] dy);
    logic [6:0] n;
    n = ({4'b0, dx} * {4'b0, dx}) + ({4'b0, dy} * {4'b0, dy});
    case (n)
      7'd1:  heur = 12'd256;
      7'd2:  heur = 12'd362;
      7'd4:  heur = 12'd512;
      7'd5:  heur = 12'd572;
      7'd8:  heur = 12'd724;
      7'd9:  heur = 12'd768;
      7'd10: heur = 12'd810;
      7'd13: heur = 12'd923;
      7'd16: heur = 12'd1024;
      7'd17: heur = 12'd1056;
      7'd18: heur = 12'd1086;
      7'd20: heur = 12'd1145;
      7'd25: heur = 12'd1280;
      7'd26: heur = 12'd1305;
      7'd29: heur = 12'd1379;
      7'd32: heur = 12'd1448;
      7'd34: heur = 12'd1493;
      7'd36: heur = 12'd1536;
      7'd37: heur = 12'd1557;
      7'd40: heur = 12'd1619;
      7'd41: heur = 12'd1639;
      7'd45: heur = 12'd1717;
      7'd49: heur = 12'd1792;
      7'd50: heur = 12'd1810;
      7'd52: heur = 12'd1846;
      7'd53: heur = 12'd1864;
      7'd58: heur = 12'd1950;
      7'd61: heur = 12'd1999;
      7'd65: heur = 12'd2064;
      7'd72: heur = 12'd2172;
      7'd74: heur = 12'd2202;
      7'd85: heur = 12'd2360;
      7'd98: heur = 12'd2534;
      default: heur = 12'd0;
    endcase
  endfunction

endpackage

@@ design/gan_div.sv @@
// gan_div: iterative floor divider, one quotient bit per cycle
// depends on gan_pkg
module gan_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              go,
  input  logic signed [gan_pkg::DIV_W-1:0]  num,
  input  logic        [15:0]                den,
  output logic                              done,
  output logic signed [gan_pkg::CELL_W-1:0] quo
);

  logic [gan_pkg::DIV_W-1:0] a_r;
  logic [15:0]               rem_r;
  logic [15:0]               den_r;
  logic                      neg_r;
  logic [4:0]                cnt_r;
  logic [16:0]               trial;
  logic                      fits;
  logic [gan_pkg::DIV_W-1:0] mag;
  logic [gan_pkg::CELL_W-1:0] qext;

  assign mag   = num[gan_pkg::DIV_W-1] ? gan_pkg::DIV_W'(-num) : gan_pkg::DIV_W'(num);
  assign trial = {rem_r, a_r[gan_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = (cnt_r == 5'd0);
  assign qext  = {1'b0, a_r};
  assign quo   = neg_r ? $signed(-(qext + gan_pkg::CELL_W'(rem_r != 16'd0)))
                       : $signed(qext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 5'd0;
    end else if (go) begin
      cnt_r <= 5'(gan_pkg::DIV_W);
    end else if (cnt_r != 5'd0) begin
      cnt_r <= cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r   <= mag;
      rem_r <= 16'd0;
      den_r <= den;
      neg_r <= num[gan_pkg::DIV_W-1];
    end else if (cnt_r != 5'd0) begin
      a_r   <= {a_r[gan_pkg::DIV_W-2:0], fits};
      rem_r <= fits ? 16'(trial - {1'b0, den_r}) : trial[15:0];
    end
  end

endmodule

@@ design/gan_ctrl.sv @@
// gan_ctrl: sequencer for commands, search and path output
// depends on gan_pkg
module gan_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  gan_pkg::stat_t stat,
  output gan_pkg::ctrl_t ctrl
);

  gan_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gan_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != gan_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gan_pkg::S_IDLE: if (start) state_nxt = gan_pkg::S_DECODE;
      gan_pkg::S_DECODE: begin
        if (stat.cmd == gan_pkg::CMD_WRITE_STATIC) state_nxt = gan_pkg::S_WSTAT;
        else if (!stat.grid_ok) state_nxt = gan_pkg::S_RESP;
        else state_nxt = gan_pkg::S_CONV_GO;
      end
      gan_pkg::S_WSTAT: state_nxt = gan_pkg::S_RESP;
      gan_pkg::S_CONV_GO: state_nxt = gan_pkg::S_CONV_RUN;
      gan_pkg::S_CONV_RUN: begin
        if (stat.div_done) state_nxt = stat.conv_last ? gan_pkg::S_DISPATCH
                                                      : gan_pkg::S_CONV_GO;
      end
      gan_pkg::S_DISPATCH: begin
        unique case (stat.cmd)
          gan_pkg::CMD_MARK_RECT:
            state_nxt = stat.rect_nonempty ? gan_pkg::S_RECT_WR : gan_pkg::S_RESP;
          gan_pkg::CMD_FIND_PATH:
            state_nxt = stat.path_ok ? gan_pkg::S_POP : gan_pkg::S_RESP;
          default: state_nxt = gan_pkg::S_RESP;
        endcase
      end
      gan_pkg::S_RECT_WR: if (stat.rect_last) state_nxt = gan_pkg::S_RESP;
      gan_pkg::S_POP: state_nxt = stat.open_empty ? gan_pkg::S_RESP : gan_pkg::S_SCAN;
      gan_pkg::S_SCAN: if (stat.scan_done) state_nxt = gan_pkg::S_POP_RD;
      gan_pkg::S_POP_RD: state_nxt = gan_pkg::S_POP_MOVE;
      gan_pkg::S_POP_MOVE: state_nxt = stat.at_goal ? gan_pkg::S_TR_WR : gan_pkg::S_NB_CHK;
      gan_pkg::S_NB_CHK: begin
        if (!stat.nb_skip) state_nxt = gan_pkg::S_NB_UPD;
        else if (stat.nb_last) state_nxt = gan_pkg::S_POP;
      end
      gan_pkg::S_NB_UPD: state_nxt = stat.nb_last ? gan_pkg::S_POP : gan_pkg::S_NB_CHK;
      gan_pkg::S_TR_WR: state_nxt = stat.tr_stop ? gan_pkg::S_EM_RD : gan_pkg::S_TR_NEXT;
      gan_pkg::S_TR_NEXT: state_nxt = gan_pkg::S_TR_WR;
      gan_pkg::S_EM_RD: state_nxt = gan_pkg::S_EM_OUT;
      gan_pkg::S_EM_OUT: state_nxt = stat.em_last ? gan_pkg::S_IDLE : gan_pkg::S_EM_RD;
      gan_pkg::S_RESP: state_nxt = gan_pkg::S_IDLE;
      default: state_nxt = gan_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_r)
      gan_pkg::S_IDLE:     ctrl.latch = start;
      gan_pkg::S_WSTAT:    ctrl.wr_static = 1'b1;
      gan_pkg::S_CONV_GO:  ctrl.conv_start = 1'b1;
      gan_pkg::S_CONV_RUN: ctrl.conv_store = stat.div_done;
      gan_pkg::S_DISPATCH: begin
        ctrl.rect_init = (stat.cmd == gan_pkg::CMD_MARK_RECT) && stat.rect_nonempty;
        ctrl.query     = (stat.cmd == gan_pkg::CMD_QUERY);
        ctrl.path_init = (stat.cmd == gan_pkg::CMD_FIND_PATH) && stat.path_ok;
      end
      gan_pkg::S_RECT_WR:  ctrl.rect_step = 1'b1;
      gan_pkg::S_POP:      ctrl.scan_init = !stat.open_empty;
      gan_pkg::S_SCAN:     ctrl.scan_step = !stat.scan_done;
      gan_pkg::S_POP_RD:   ctrl.pop_rdlast = 1'b1;
      gan_pkg::S_POP_MOVE: begin
        ctrl.pop_move = 1'b1;
        ctrl.tr_init  = stat.at_goal;
      end
      gan_pkg::S_NB_CHK: begin
        ctrl.nb_rd   = !stat.nb_skip;
        ctrl.nb_next = stat.nb_skip;
      end
      gan_pkg::S_NB_UPD: begin
        ctrl.nb_upd  = 1'b1;
        ctrl.nb_next = 1'b1;
      end
      gan_pkg::S_TR_WR: begin
        ctrl.tr_wr   = 1'b1;
        ctrl.em_init = stat.tr_stop;
      end
      gan_pkg::S_TR_NEXT:  ctrl.tr_next = 1'b1;
      gan_pkg::S_EM_RD:    ctrl.em_rd = 1'b1;
      gan_pkg::S_EM_OUT:   ctrl.em_out = 1'b1;
      gan_pkg::S_RESP:     ctrl.resp = 1'b1;
      default:             ctrl = '0;
    endcase
  end

endmodule

@@ design/gan_dp.sv @@
// gan_dp: registers, maps, search memories and arithmetic of the navigator
// depends on gan_pkg and gan_div
module gan_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic [1:0]          in_command,
  input  logic [5:0]          in_cell_index,
  input  logic signed [23:0]  in_x_a,
  input  logic signed [23:0]  in_y_a,
  input  logic signed [23:0]  in_x_b,
  input  logic signed [23:0]  in_y_b,
  input  logic                in_block_value,
  input  gan_pkg::ctrl_t      ctrl,
  output gan_pkg::stat_t      stat,
  output logic                out_valid,
  output logic                out_ok,
  output logic [2:0]          out_cell_x,
  output logic [2:0]          out_cell_y,
  output logic signed [23:0]  out_center_x,
  output logic signed [23:0]  out_center_y,
  output logic [15:0]         out_change_count,
  output logic                out_last
);

  localparam int CELL_W = gan_pkg::CELL_W;

  logic [23:0] origin_x_r, origin_y_r;
  logic [15:0] cell_size_r;
  logic [3:0]  grid_w_r, grid_h_r;

  gan_pkg::cmd_t      cmd_r;
  logic [5:0]         cell_idx_r;
  logic               bv_r;
  logic signed [24:0] op_r [4];
  logic               ok_r;
  logic [15:0]        version_r;
  logic [gan_pkg::CELLS-1:0] static_map_r, dyn_map_r;
  logic [gan_pkg::CELLS-1:0] cost_valid_r, came_valid_r;

  logic [1:0]              conv_k_r;
  logic signed [CELL_W-1:0] cell_r [4];
  logic [2:0] rx_r, ry_r;

  logic [gan_pkg::HEAP_CW-1:0] open_cnt_r, scan_j_r;
  logic                        pend_r;
  logic [gan_pkg::HEAP_AW-1:0] cmp_pos_r, best_pos_r;
  logic [21:0]                 best_key_r;
  logic [15:0]                 base_r;
  logic [2:0]                  nb_k_r;
  logic [5:0]                  tr_i_r, em_ptr_r;
  logic [6:0]                  tr_n_r;

  logic [21:0] heap_mem [gan_pkg::HEAP_DEPTH];
  logic [15:0] cost_mem [gan_pkg::CELLS];
  logic [5:0]  came_mem [gan_pkg::CELLS];
  logic [5:0]  rev_mem  [gan_pkg::CELLS];
  logic [21:0] heap_q_r;
  logic [15:0] cost_q_r;
  logic [5:0]  came_q_r, rev_q_r;

  logic                        heap_we, heap_re, cost_we, cost_re;
  logic [gan_pkg::HEAP_AW-1:0] heap_wa, heap_ra;
  logic [21:0]                 heap_wd;
  logic [5:0]                  cost_wa, cost_ra;
  logic [15:0]                 cost_wd;

  logic [3:0]  gw, gh;
  logic [15:0] cs_eff;
  logic        grid_ok;

  localparam int DIV_W_L = gan_pkg::DIV_W;
  logic signed [DIV_W_L-1:0] div_num;
  logic signed [24:0]       op_k;
  logic [23:0]              org_k;
  logic                     div_done;
  logic signed [CELL_W-1:0] div_quo;

  logic [2:0] sx, sy, gx, gy, cx0, cy0, cx1, cy1;
  logic       s_in, g_in;

  logic signed [4:0] nx_s, ny_s;
  logic signed [1:0] dir_dx_w, dir_dy_w;
  logic [2:0]  cur_x, cur_y, nx, ny, hdx, hdy;
  logic        nb_in, nb_corner;
  logic [15:0] ng, nf;
  logic        improve, push_ok;
  logic        scan_more;

  logic signed [23:0] minx, maxx, miny, maxy;

  function automatic logic [5:0] cell_at(input logic [2:0] x, input logic [2:0] y,
                                         input logic [3:0] w);
    cell_at = 6'((7'(y) * 7'(w)) + 7'(x));
  endfunction

  function automatic logic in_span(input logic signed [CELL_W-1:0] v, input logic [3:0] lim);
    in_span = (v >= 0) && (v < $signed({{(CELL_W-4){1'b0}}, lim}));
  endfunction

  function automatic logic [2:0] clampc(input logic signed [CELL_W-1:0] v,
                                        input logic [3:0] lim);
    logic [3:0] top;
    top = lim - 4'd1;
    if (v < 0) clampc = 3'd0;
    else if (v > $signed({{(CELL_W-4){1'b0}}, top})) clampc = top[2:0];
    else clampc = v[2:0];
  endfunction

  function automatic logic [23:0] centre(input logic [2:0] c, input logic [23:0] org,
                                         input logic [15:0] cs);
    logic [19:0]        prod;
    logic signed [25:0] sum;
    prod = 20'({c, 1'b1}) * 20'(cs);
    sum  = $signed({{2{org[23]}}, org}) + $signed({7'b0, prod[19:1]});
    if (sum > 26'sd8388607) centre = 24'h7fffff;
    else if (sum < -26'sd8388608) centre = 24'h800000;
    else centre = sum[23:0];
  endfunction

  function automatic logic blk(input logic [5:0] i, input logic [gan_pkg::CELLS-1:0] sm,
                               input logic [gan_pkg::CELLS-1:0] dm);
    blk = sm[i] | dm[i];
  endfunction

  assign gw      = (grid_w_r > 4'(gan_pkg::GRID_W)) ? 4'(gan_pkg::GRID_W) : grid_w_r;
  assign gh      = (grid_h_r > 4'(gan_pkg::GRID_H)) ? 4'(gan_pkg::GRID_H) : grid_h_r;
  assign cs_eff  = (cell_size_r == 16'd0) ? 16'd1 : cell_size_r;
  assign grid_ok = (gw != 4'd0) && (gh != 4'd0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= 24'd0;
      origin_y_r  <= 24'd0;
      cell_size_r <= 16'd256;
      grid_w_r    <= 4'd0;
      grid_h_r    <= 4'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        gan_pkg::REG_ORIGIN_X:  origin_x_r  <= cfg_data;
        gan_pkg::REG_ORIGIN_Y:  origin_y_r  <= cfg_data;
        gan_pkg::REG_CELL_SIZE: cell_size_r <= cfg_data[15:0];
        gan_pkg::REG_GRID_W:    grid_w_r    <= cfg_data[3:0];
        gan_pkg::REG_GRID_H:    grid_h_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // request capture
  assign minx = (in_x_a < in_x_b) ? in_x_a : in_x_b;
  assign maxx = (in_x_a < in_x_b) ? in_x_b : in_x_a;
  assign miny = (in_y_a < in_y_b) ? in_y_a : in_y_b;
  assign maxy = (in_y_a < in_y_b) ? in_y_b : in_y_a;

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_r      <= gan_pkg::cmd_t'(in_command);
      cell_idx_r <= in_cell_index;
      bv_r       <= in_block_value;
      if (gan_pkg::cmd_t'(in_command) == gan_pkg::CMD_MARK_RECT) begin
        op_r[0] <= {minx[23], minx};
        op_r[1] <= {miny[23], miny};
        op_r[2] <= $signed({maxx[23], maxx}) - 25'sd1;
        op_r[3] <= $signed({maxy[23], maxy}) - 25'sd1;
      end else begin
        op_r[0] <= {in_x_a[23], in_x_a};
        op_r[1] <= {in_y_a[23], in_y_a};
        op_r[2] <= {in_x_b[23], in_x_b};
        op_r[3] <= {in_y_b[23], in_y_b};
      end
    end
  end

  // world to cell conversion
  assign op_k    = op_r[conv_k_r];
  assign org_k   = conv_k_r[0] ? origin_y_r : origin_x_r;
  assign div_num = $signed({op_k[24], op_k}) - $signed({{2{org_k[23]}}, org_k});

  gan_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (ctrl.conv_start),
    .num  (div_num),
    .den  (cs_eff),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_k_r <= 2'd0;
    end else if (ctrl.latch) begin
      conv_k_r <= 2'd0;
    end else if (ctrl.conv_store) begin
      conv_k_r <= conv_k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.conv_store) cell_r[conv_k_r] <= div_quo;
  end

  assign sx   = cell_r[0][2:0];
  assign sy   = cell_r[1][2:0];
  assign gx   = cell_r[2][2:0];
  assign gy   = cell_r[3][2:0];
  assign s_in = in_span(cell_r[0], gw) && in_span(cell_r[1], gh);
  assign g_in = in_span(cell_r[2], gw) && in_span(cell_r[3], gh);
  assign cx0  = clampc(cell_r[0], gw);
  assign cy0  = clampc(cell_r[1], gh);
  assign cx1  = clampc(cell_r[2], gw);
  assign cy1  = clampc(cell_r[3], gh);

  // maps, version and ok flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      static_map_r <= '0;
      dyn_map_r    <= '0;
      version_r    <= 16'd0;
      ok_r         <= 1'b0;
    end else begin
      if (ctrl.latch) ok_r <= 1'b0;
      if (ctrl.wr_static && grid_ok && ({2'b0, cell_idx_r} < (8'(gw) * 8'(gh)))) begin
        static_map_r[cell_idx_r] <= bv_r;
        ok_r <= 1'b1;
      end
      if (ctrl.rect_step) begin
        dyn_map_r[cell_at(rx_r, ry_r, gw)] <= bv_r;
        if (stat.rect_last) begin
          version_r <= version_r + 16'd1;
          ok_r      <= 1'b1;
        end
      end
      if (ctrl.query) begin
        ok_r <= s_in && !blk(cell_at(sx, sy, gw), static_map_r, dyn_map_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rect_init) begin
      rx_r <= cx0;
      ry_r <= cy0;
    end else if (ctrl.rect_step) begin
      if (rx_r == cx1) begin
        rx_r <= cx0;
        ry_r <= ry_r + 3'd1;
      end else begin
        rx_r <= rx_r + 3'd1;
      end
    end
  end

  // open list scan and neighbor expansion
  assign cur_x     = best_key_r[2:0];
  assign cur_y     = best_key_r[5:3];
  assign nx_s      = $signed({2'b0, cur_x}) + {{3{dir_dx_w[1]}}, dir_dx_w};
  assign ny_s      = $signed({2'b0, cur_y}) + {{3{dir_dy_w[1]}}, dir_dy_w};
  assign dir_dx_w  = gan_pkg::dir_dx(nb_k_r);
  assign dir_dy_w  = gan_pkg::dir_dy(nb_k_r);
  assign nx        = nx_s[2:0];
  assign ny        = ny_s[2:0];
  assign nb_in     = (nx_s >= 0) && (nx_s < $signed({1'b0, gw}))
                  && (ny_s >= 0) && (ny_s < $signed({1'b0, gh}));
  assign nb_corner = nb_k_r[2] && blk(cell_at(cur_x, ny, gw), static_map_r, dyn_map_r)
                              && blk(cell_at(nx, cur_y, gw), static_map_r, dyn_map_r);
  assign hdx       = (nx > gx) ? nx - gx : gx - nx;
  assign hdy       = (ny > gy) ? ny - gy : gy - ny;
  assign ng        = base_r + (nb_k_r[2] ? gan_pkg::DIAG_COST : gan_pkg::ORTHO_COST);
  assign nf        = ng + {4'b0, gan_pkg::heur(hdx, hdy)};
  assign improve   = !cost_valid_r[{ny, nx}] || (ng < cost_q_r);
  assign push_ok   = open_cnt_r < gan_pkg::HEAP_CW'(gan_pkg::HEAP_DEPTH);
  assign scan_more = scan_j_r < open_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_cnt_r   <= '0;
      pend_r       <= 1'b0;
      cost_valid_r <= '0;
      came_valid_r <= '0;
    end else begin
      if (ctrl.path_init) begin
        open_cnt_r   <= gan_pkg::HEAP_CW'(1);
        cost_valid_r <= gan_pkg::CELLS'(1) << {sy, sx};
        came_valid_r <= '0;
      end
      if (ctrl.pop_move) open_cnt_r <= open_cnt_r - gan_pkg::HEAP_CW'(1);
      if (ctrl.nb_upd && improve) begin
        cost_valid_r[{ny, nx}] <= 1'b1;
        came_valid_r[{ny, nx}] <= 1'b1;
        if (push_ok) open_cnt_r <= open_cnt_r + gan_pkg::HEAP_CW'(1);
      end
      if (ctrl.scan_init) pend_r <= 1'b0;
      else if (ctrl.scan_step) pend_r <= scan_more;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_init) begin
      scan_j_r   <= '0;
      best_key_r <= '1;
    end else if (ctrl.scan_step) begin
      if (scan_more) begin
        scan_j_r  <= scan_j_r + gan_pkg::HEAP_CW'(1);
        cmp_pos_r <= scan_j_r[gan_pkg::HEAP_AW-1:0];
      end
      if (pend_r && (heap_q_r < best_key_r)) begin
        best_key_r <= heap_q_r;
        best_pos_r <= cmp_pos_r;
      end
    end
    if (ctrl.pop_move) base_r <= cost_q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nb_k_r <= 3'd0;
    end else if (ctrl.pop_move) begin
      nb_k_r <= 3'd0;
    end else if (ctrl.nb_next) begin
      nb_k_r <= nb_k_r + 3'd1;
    end
  end

  // memory ports
  always_comb begin
    heap_we = 1'b0;
    heap_wa = '0;
    heap_wd = '0;
    if (ctrl.path_init) begin
      heap_we = 1'b1;
      heap_wd = {4'b0, gan_pkg::heur((sx > gx) ? sx - gx : gx - sx,
                                     (sy > gy) ? sy - gy : gy - sy), sy, sx};
    end else if (ctrl.pop_move) begin
      heap_we = 1'b1;
      heap_wa = best_pos_r;
      heap_wd = heap_q_r;
    end else if (ctrl.nb_upd && improve && push_ok) begin
      heap_we = 1'b1;
      heap_wa = open_cnt_r[gan_pkg::HEAP_AW-1:0];
      heap_wd = {nf, ny, nx};
    end
    heap_re = (ctrl.scan_step && scan_more) || ctrl.pop_rdlast;
    heap_ra = ctrl.pop_rdlast ? gan_pkg::HEAP_AW'(open_cnt_r - gan_pkg::HEAP_CW'(1))
                              : scan_j_r[gan_pkg::HEAP_AW-1:0];
    cost_we = ctrl.path_init || (ctrl.nb_upd && improve);
    cost_wa = ctrl.path_init ? {sy, sx} : {ny, nx};
    cost_wd = ctrl.path_init ? 16'd0 : ng;
    cost_re = ctrl.pop_rdlast || ctrl.nb_rd;
    cost_ra = ctrl.pop_rdlast ? {cur_y, cur_x} : {ny, nx};
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) heap_q_r <= heap_mem[heap_ra];
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    if (cost_re) cost_q_r <= cost_mem[cost_ra];
  end

  always_ff @(posedge clk) begin
    if (ctrl.nb_upd && improve) came_mem[{ny, nx}] <= {cur_y, cur_x};
    if (ctrl.tr_wr) came_q_r <= came_mem[tr_i_r];
  end

  always_ff @(posedge clk) begin
    if (ctrl.tr_wr) rev_mem[tr_n_r[5:0]] <= tr_i_r;
    if (ctrl.em_rd) rev_q_r <= rev_mem[em_ptr_r];
  end

  // path walk back and output order
  always_ff @(posedge clk) begin
    if (ctrl.tr_init) begin
      tr_i_r <= {gy, gx};
      tr_n_r <= 7'd0;
    end else begin
      if (ctrl.tr_wr) tr_n_r <= tr_n_r + 7'd1;
      if (ctrl.tr_next) tr_i_r <= came_q_r;
    end
    if (ctrl.em_init) em_ptr_r <= tr_n_r[5:0];
    else if (ctrl.em_out) em_ptr_r <= em_ptr_r - 6'd1;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctrl.resp || ctrl.em_out;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.resp) begin
      out_ok           <= ok_r;
      out_cell_x       <= 3'd0;
      out_cell_y       <= 3'd0;
      out_center_x     <= 24'sd0;
      out_center_y     <= 24'sd0;
      out_change_count <= version_r;
      out_last         <= 1'b1;
    end else if (ctrl.em_out) begin
      out_ok           <= 1'b1;
      out_cell_x       <= rev_q_r[2:0];
      out_cell_y       <= rev_q_r[5:3];
      out_center_x     <= centre(rev_q_r[2:0], origin_x_r, cs_eff);
      out_center_y     <= centre(rev_q_r[5:3], origin_y_r, cs_eff);
      out_change_count <= version_r;
      out_last         <= (em_ptr_r == 6'd0);
    end
  end

  // status to the controller
  always_comb begin
    stat.cmd           = cmd_r;
    stat.grid_ok       = grid_ok;
    stat.div_done      = div_done;
    stat.conv_last     = (conv_k_r == 2'd3);
    stat.rect_nonempty = (cx0 <= cx1) && (cy0 <= cy1);
    stat.rect_last     = (rx_r == cx1) && (ry_r == cy1);
    stat.path_ok       = s_in && g_in
                      && !blk(cell_at(sx, sy, gw), static_map_r, dyn_map_r)
                      && !blk(cell_at(gx, gy, gw), static_map_r, dyn_map_r);
    stat.open_empty    = (open_cnt_r == '0);
    stat.scan_done     = !scan_more && !pend_r;
    stat.at_goal       = (best_key_r[5:0] == {gy, gx});
    stat.nb_skip       = !nb_in || blk(cell_at(nx, ny, gw), static_map_r, dyn_map_r)
                      || nb_corner;
    stat.nb_last       = (nb_k_r == 3'd7);
    stat.tr_stop       = !came_valid_r[tr_i_r] || (tr_n_r == 7'd63);
    stat.em_last       = (em_ptr_r == 6'd0);
  end

`ifndef SYNTH
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_cnt_r <= gan_pkg::HEAP_CW'(gan_pkg::HEAP_DEPTH))
    else $error("open list count beyond depth");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop_move |=> open_cnt_r == $past(open_cnt_r) - gan_pkg::HEAP_CW'(1))
    else $error("pop did not shrink open list");
  a_version: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.rect_step && stat.rect_last) |=> version_r == $past(version_r) + 16'd1)
    else $error("map version not bumped after rectangle");
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.resp || ctrl.em_out) |=> out_valid)
    else $error("result strobe missing");
`endif

endmodule

@@ design/grid_astar_navigator.sv @@
// grid_astar_navigator: top level of the occupancy grid navigator
// depends on gan_pkg, gan_ctrl, gan_dp (and gan_div below it)
//
//  channel   handshake              payload
//  request   start / busy           in_command .. in_block_value
//  result    out_valid strobe       out_ok .. out_last
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// static write goes straight to the response; query and rectangle marking first
// convert the world points to cells with the divider, then marking writes one cell at a time
// a path search also divides first, then per pop scans the open list memory
// (one entry a cycle), then checks each of the eight neighbors and updates those that pass
// path cells leave one by one after the walk back; reset clears maps and version
// results cannot be held off by the receiver
module grid_astar_navigator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [5:0]         in_cell_index,
  input  logic signed [23:0] in_x_a,
  input  logic signed [23:0] in_y_a,
  input  logic signed [23:0] in_x_b,
  input  logic signed [23:0] in_y_b,
  input  logic               in_block_value,
  output logic               out_valid,
  output logic               out_ok,
  output logic [2:0]         out_cell_x,
  output logic [2:0]         out_cell_y,
  output logic signed [23:0] out_center_x,
  output logic signed [23:0] out_center_y,
  output logic [15:0]        out_change_count,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  gan_pkg::ctrl_t ctrl;
  gan_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  gan_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .ctrl (ctrl)
  );

  gan_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_command      (in_command),
    .in_cell_index   (in_cell_index),
    .in_x_a          (in_x_a),
    .in_y_a          (in_y_a),
    .in_x_b          (in_x_b),
    .in_y_b          (in_y_b),
    .in_block_value  (in_block_value),
    .ctrl            (ctrl),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_cell_x      (out_cell_x),
    .out_cell_y      (out_cell_y),
    .out_center_x    (out_center_x),
    .out_center_y    (out_center_y),
    .out_change_count(out_change_count),
    .out_last        (out_last)
  );

endmodule

@@ verif/gan_checker.sv @@
// gan_checker: watches the request, result and config channels of grid_astar_navigator,
// predicts every result from its own copy of the grid state and compares field by field
// depends on gan_pkg for command and register codes
module gan_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_cell_index,
  input  logic [23:0] in_x_a,
  input  logic [23:0] in_y_a,
  input  logic [23:0] in_x_b,
  input  logic [23:0] in_y_b,
  input  logic        in_block_value,
  input  logic        out_valid,
  input  logic        out_ok,
  input  logic [2:0]  out_cell_x,
  input  logic [2:0]  out_cell_y,
  input  logic [23:0] out_center_x,
  input  logic [23:0] out_center_y,
  input  logic [15:0] out_change_count,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        ok;
    logic [2:0]  cx;
    logic [2:0]  cy;
    logic [23:0] px;
    logic [23:0] py;
    logic [15:0] count;
    logic        last;
  } nav_result_t;

  nav_result_t expected_q[$];

  logic [23:0] org_x, org_y;
  logic [15:0] csize;
  logic [3:0]  width_r, height_r;
  bit          static_blk[64];
  bit          dyn_blk[64];
  logic [15:0] version;
  int          dist_tab[64];

  const int step_x[8] = '{1, -1, 0, 0, 1, 1, -1, -1};
  const int step_y[8] = '{0, 0, 1, -1, 1, -1, 1, -1};

  function automatic int round_sqrt(longint v);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    if (v - r * r > r) r++;
    return int'(r);
  endfunction

  function automatic longint sx24(logic [23:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint cell_span();
    return (csize == 0) ? 1 : longint'(csize);
  endfunction

  function automatic longint world_to_cell(longint p, logic [23:0] org);
    longint a, q;
    a = p - sx24(org);
    q = a / cell_span();
    if ((a % cell_span()) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic [23:0] centre(int c, logic [23:0] org);
    longint v;
    v = sx24(org) + (((2 * c + 1) * cell_span()) >>> 1);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic bit is_blocked(int i);
    return static_blk[i] | dyn_blk[i];
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic add_result(bit ok, int cx, int cy, logic [23:0] px, logic [23:0] py,
                            bit last);
    nav_result_t r;
    r.ok = ok; r.cx = cx[2:0]; r.cy = cy[2:0]; r.px = px; r.py = py;
    r.count = version; r.last = last;
    expected_q.push_back(r);
  endtask

  // a* search; returns path length, 0 when no path
  task automatic search_path(logic [23:0] xa, logic [23:0] ya, logic [23:0] xb,
                             logic [23:0] yb, int gw, int gh, output int n);
    longint sx, sy, gx, gy;
    int s, g, cnt, best, cur, cx, cy, nx, ny, ni, ng, dx, dy, i;
    int cost[64], from[64], open_f[512], open_i[512], rev[64];
    bit cval[64], fval[64], found;
    n = 0;
    found = 0;
    sx = world_to_cell(sx24(xa), org_x); sy = world_to_cell(sx24(ya), org_y);
    gx = world_to_cell(sx24(xb), org_x); gy = world_to_cell(sx24(yb), org_y);
    if (sx < 0 || sx >= gw || sy < 0 || sy >= gh) return;
    if (gx < 0 || gx >= gw || gy < 0 || gy >= gh) return;
    s = int'(sy * gw + sx);
    g = int'(gy * gw + gx);
    if (is_blocked(s) || is_blocked(g)) return;
    foreach (cval[j]) begin
      cval[j] = 0;
      fval[j] = 0;
    end
    cost[s] = 0;
    cval[s] = 1;
    dx = int'((sx > gx) ? sx - gx : gx - sx);
    dy = int'((sy > gy) ? sy - gy : gy - sy);
    open_f[0] = dist_tab[dy * 8 + dx];
    open_i[0] = s;
    cnt = 1;
    while (cnt > 0 && !found) begin
      best = 0;
      for (int j = 1; j < cnt; j++)
        if (open_f[j] < open_f[best] ||
            (open_f[j] == open_f[best] && open_i[j] < open_i[best])) best = j;
      cur = open_i[best];
      open_f[best] = open_f[cnt - 1];
      open_i[best] = open_i[cnt - 1];
      cnt--;
      if (cur == g) begin
        found = 1;
      end else begin
        cx = cur % gw;
        cy = cur / gw;
        for (int k = 0; k < 8; k++) begin
          nx = cx + step_x[k];
          ny = cy + step_y[k];
          if (nx < 0 || nx >= gw || ny < 0 || ny >= gh) continue;
          ni = ny * gw + nx;
          if (is_blocked(ni)) continue;
          // no corner cutting when both side cells are blocked
          if (k >= 4 && is_blocked(ny * gw + cx) && is_blocked(cy * gw + nx)) continue;
          ng = cost[cur] + ((k < 4) ? int'(gan_pkg::ORTHO_COST) : int'(gan_pkg::DIAG_COST));
          if (!cval[ni] || ng < cost[ni]) begin
            dx = (nx > gx) ? nx - int'(gx) : int'(gx) - nx;
            dy = (ny > gy) ? ny - int'(gy) : int'(gy) - ny;
            cost[ni] = ng;
            cval[ni] = 1;
            from[ni] = cur;
            fval[ni] = 1;
            if (cnt < gan_pkg::HEAP_DEPTH) begin
              open_f[cnt] = ng + dist_tab[dy * 8 + dx];
              open_i[cnt] = ni;
              cnt++;
            end
          end
        end
      end
    end
    if (!found) return;
    i = g;
    while (n < 64) begin
      rev[n] = i;
      n++;
      if (!fval[i]) break;
      i = from[i];
    end
    for (int k = 0; k < n; k++) begin
      i = rev[n - 1 - k];
      add_result(1, i % gw, i / gw, centre(i % gw, org_x), centre(i / gw, org_y),
                 k == n - 1);
    end
  endtask

  task automatic predict(logic [1:0] cmd, logic [5:0] ci, logic [23:0] xa,
                         logic [23:0] ya, logic [23:0] xb, logic [23:0] yb, logic bv);
    int gw, gh, n;
    bit ok;
    longint x0, x1, y0, y1, cx0, cx1, cy0, cy1, qx, qy;
    gw = (width_r > gan_pkg::GRID_W) ? gan_pkg::GRID_W : int'(width_r);
    gh = (height_r > gan_pkg::GRID_H) ? gan_pkg::GRID_H : int'(height_r);
    ok = 0;
    n = 0;
    if (gw > 0 && gh > 0) begin
      case (gan_pkg::cmd_t'(cmd))
        gan_pkg::CMD_WRITE_STATIC: begin
          if (int'(ci) < gw * gh) begin
            static_blk[ci] = bv;
            ok = 1;
          end
        end
        gan_pkg::CMD_MARK_RECT: begin
          x0 = (sx24(xa) < sx24(xb)) ? sx24(xa) : sx24(xb);
          x1 = ((sx24(xa) < sx24(xb)) ? sx24(xb) : sx24(xa)) - 1;
          y0 = (sx24(ya) < sx24(yb)) ? sx24(ya) : sx24(yb);
          y1 = ((sx24(ya) < sx24(yb)) ? sx24(yb) : sx24(ya)) - 1;
          cx0 = clip(world_to_cell(x0, org_x), 0, gw - 1);
          cx1 = clip(world_to_cell(x1, org_x), 0, gw - 1);
          cy0 = clip(world_to_cell(y0, org_y), 0, gh - 1);
          cy1 = clip(world_to_cell(y1, org_y), 0, gh - 1);
          if (cx0 <= cx1 && cy0 <= cy1) begin
            for (longint y = cy0; y <= cy1; y++)
              for (longint x = cx0; x <= cx1; x++) dyn_blk[y * gw + x] = bv;
            version = version + 16'd1;
            ok = 1;
          end
        end
        gan_pkg::CMD_QUERY: begin
          qx = world_to_cell(sx24(xa), org_x);
          qy = world_to_cell(sx24(ya), org_y);
          if (qx >= 0 && qx < gw && qy >= 0 && qy < gh)
            ok = !is_blocked(int'(qy * gw + qx));
        end
        default: search_path(xa, ya, xb, yb, gw, gh, n);
      endcase
    end
    if (n == 0) add_result(ok, 0, 0, '0, '0, 1);
  endtask

  always @(posedge clk) begin
    nav_result_t e;
    if (!rst_n) begin
      org_x = '0; org_y = '0; csize = 16'd256; width_r = '0; height_r = '0;
      version = '0;
      foreach (static_blk[i]) begin
        static_blk[i] = 0;
        dyn_blk[i] = 0;
        dist_tab[i] = round_sqrt(longint'((i % 8) * (i % 8) + (i / 8) * (i / 8)) << 16);
      end
      expected_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gan_pkg::REG_ORIGIN_X:  org_x = cfg_data;
          gan_pkg::REG_ORIGIN_Y:  org_y = cfg_data;
          gan_pkg::REG_CELL_SIZE: csize = cfg_data[15:0];
          gan_pkg::REG_GRID_W:    width_r = cfg_data[3:0];
          gan_pkg::REG_GRID_H:    height_r = cfg_data[3:0];
          default: ;
        endcase
      end
      if (start && !busy)
        predict(in_command, in_cell_index, in_x_a, in_y_a, in_x_b, in_y_b, in_block_value);
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result ok=%0d x=%0d y=%0d", out_ok,
                                    out_cell_x, out_cell_y);
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.ok !== out_ok || e.cx !== out_cell_x || e.cy !== out_cell_y ||
              e.px !== out_center_x || e.py !== out_center_y ||
              e.count !== out_change_count || e.last !== out_last) begin
            if (errors < 10)
              $display("mismatch exp ok=%0d x=%0d y=%0d cx=%h cy=%h cnt=%0d last=%0d",
                       e.ok, e.cx, e.cy, e.px, e.py, e.count, e.last,
                       " | got ok=%0d x=%0d y=%0d cx=%h cy=%h cnt=%0d last=%0d",
                       out_ok, out_cell_x, out_cell_y, out_center_x, out_center_y,
                       out_change_count, out_last);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

@@ verif/tb_grid_astar_navigator.sv @@
// tb_grid_astar_navigator: drives config and requests into grid_astar_navigator and
// gives the verdict; checking is done by gan_checker beside the block
// depends on gan_pkg, gan_checker and the navigator rtl
module tb_grid_astar_navigator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 500000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [5:0]  in_cell_index = '0;
  logic [23:0] in_x_a = '0, in_y_a = '0, in_x_b = '0, in_y_b = '0;
  logic        in_block_value = 0;
  logic        out_valid, out_ok, out_last;
  logic [2:0]  out_cell_x, out_cell_y;
  logic [23:0] out_center_x, out_center_y;
  logic [15:0] out_change_count;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  int          errors, pending;
  int          quiet = 0;

  // current grid for building in-range points
  longint g_ox, g_oy, g_cs;
  int     g_w, g_h;
  bit     no_gaps;

  grid_astar_navigator i_dut (.*);

  gan_checker i_checker (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic set_grid(longint ox, longint oy, int cs, int w, int h);
    logic [23:0] vals[5];
    logic [2:0]  regs[5];
    vals = '{ox[23:0], oy[23:0], 24'(cs), 24'(w), 24'(h)};
    regs = '{gan_pkg::REG_ORIGIN_X, gan_pkg::REG_ORIGIN_Y, gan_pkg::REG_CELL_SIZE,
             gan_pkg::REG_GRID_W, gan_pkg::REG_GRID_H};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 0;
    g_ox = ox; g_oy = oy; g_cs = (cs == 0) ? 1 : cs;
    g_w = (w > 8) ? 8 : w; g_h = (h > 8) ? 8 : h;
  endtask

  task automatic request(gan_pkg::cmd_t cmd, int ci, longint xa, longint ya, longint xb,
                         longint yb, bit bv);
    int g;
    start <= 1;
    in_command <= cmd;
    in_cell_index <= ci[5:0];
    in_x_a <= xa[23:0]; in_y_a <= ya[23:0];
    in_x_b <= xb[23:0]; in_y_b <= yb[23:0];
    in_block_value <= bv;
    do @(posedge clk); while (busy);
    g = $urandom_range(0, 9);
    if (no_gaps) g = 0;
    else if (g < 5) g = 0;
    else if (g < 9) g = $urandom_range(1, 3);
    else g = $urandom_range(5, 40);
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic longint clamp24(longint v);
    return (v > 8388607) ? 8388607 : ((v < -8388608) ? -8388608 : v);
  endfunction

  function automatic longint pick(longint org, int n);
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return clamp24(org + $urandom_range(0, int'(g_cs * (n > 0 ? n : 1)) - 1));
    if (r < 9) return clamp24(org - g_cs + $urandom_range(0, int'(g_cs * (n + 2))));
    return longint'($signed(24'($urandom())));
  endfunction

  // world point in the middle of a cell
  function automatic longint mid(longint org, int c);
    return clamp24(org + c * g_cs + g_cs / 2);
  endfunction

  task automatic random_items(int count);
    gan_pkg::cmd_t c;
    int            r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      c = (r < 2) ? gan_pkg::CMD_WRITE_STATIC : (r < 4) ? gan_pkg::CMD_MARK_RECT
        : (r < 5) ? gan_pkg::CMD_QUERY : gan_pkg::CMD_FIND_PATH;
      request(c, $urandom_range(0, 63), pick(g_ox, g_w), pick(g_oy, g_h),
              pick(g_ox, g_w), pick(g_oy, g_h), $urandom_range(0, 9) < 4);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // no grid yet
    request(gan_pkg::CMD_WRITE_STATIC, 0, 0, 0, 0, 0, 1);
    request(gan_pkg::CMD_MARK_RECT, 0, 0, 0, 1000, 1000, 1);
    request(gan_pkg::CMD_QUERY, 0, 100, 100, 0, 0, 0);
    request(gan_pkg::CMD_FIND_PATH, 0, 100, 100, 500, 500, 0);
    drain();

    set_grid(0, 0, 256, 8, 8);
    request(gan_pkg::CMD_WRITE_STATIC, 63, 0, 0, 0, 0, 1);
    request(gan_pkg::CMD_WRITE_STATIC, 0, 0, 0, 0, 0, 0);
    request(gan_pkg::CMD_QUERY, 0, mid(0, 7), mid(0, 7), 0, 0, 0);
    request(gan_pkg::CMD_QUERY, 0, -1, -1, 0, 0, 0);
    request(gan_pkg::CMD_QUERY, 0, 8388607, 8388607, 0, 0, 0);
    request(gan_pkg::CMD_MARK_RECT, 0, -8388608, -8388608, -8388608, -8388608, 1);
    request(gan_pkg::CMD_MARK_RECT, 0, 8388607, 8388607, 8388600, 8388600, 1);
    request(gan_pkg::CMD_MARK_RECT, 0, 8388607, 8388607, -8388608, -8388608, 0);
    request(gan_pkg::CMD_WRITE_STATIC, 63, 0, 0, 0, 0, 0);
    request(gan_pkg::CMD_FIND_PATH, 0, mid(0, 0), mid(0, 0), mid(0, 7), mid(0, 7), 0);
    request(gan_pkg::CMD_MARK_RECT, 0, 1024, 0, 1280, 2048, 1);
    request(gan_pkg::CMD_FIND_PATH, 0, mid(0, 0), mid(0, 0), mid(0, 7), mid(0, 7), 0);
    request(gan_pkg::CMD_FIND_PATH, 0, mid(0, 4), mid(0, 0), mid(0, 7), mid(0, 7), 0);
    request(gan_pkg::CMD_FIND_PATH, 0, mid(0, 0), mid(0, 0), 5000, 100, 0);
    request(gan_pkg::CMD_MARK_RECT, 0, 1024, 0, 1024, 2048, 1);
    request(gan_pkg::CMD_MARK_RECT, 0, -8388608, -8388608, 8388607, 8388607, 0);
    request(gan_pkg::CMD_WRITE_STATIC, 1, 0, 0, 0, 0, 1);
    request(gan_pkg::CMD_WRITE_STATIC, 8, 0, 0, 0, 0, 1);
    request(gan_pkg::CMD_FIND_PATH, 0, mid(0, 0), mid(0, 0), mid(0, 1), mid(0, 1), 0);
    request(gan_pkg::CMD_WRITE_STATIC, 8, 0, 0, 0, 0, 0);
    request(gan_pkg::CMD_FIND_PATH, 0, mid(0, 0), mid(0, 0), mid(0, 1), mid(0, 1), 0);
    no_gaps = 1;
    random_items(16);
    no_gaps = 0;
    drain();

    set_grid(-8388608, -1000, 0, 15, 8);
    request(gan_pkg::CMD_WRITE_STATIC, 63, 0, 0, 0, 0, 1);
    random_items(16);
    drain();

    set_grid(8388000, 8388607, 65535, 3, 5);
    request(gan_pkg::CMD_WRITE_STATIC, 63, 0, 0, 0, 0, 1);
    random_items(16);
    drain();

    set_grid(1234, -5678, 100, 8, 0);
    random_items(5);
    drain();

    set_grid(-300, 777, 37, 7, 15);
    random_items(15);
    drain();

    set_grid(0, 0, 256, 8, 8);
    random_items(15);
    drain();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
